>>> hw/rtl/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg
// shared types and operation codes for the rectangle algebra unit
// ----------------------------------------------------------------------------
`default_nettype none

package rau_pkg;

  localparam logic [2:0] CMD_POINT_IN  = 3'd0;
  localparam logic [2:0] CMD_IS_EMPTY  = 3'd1;
  localparam logic [2:0] CMD_EQUAL     = 3'd2;
  localparam logic [2:0] CMD_INFLATE   = 3'd3;
  localparam logic [2:0] CMD_OFFSET    = 3'd4;
  localparam logic [2:0] CMD_INTERSECT = 3'd5;
  localparam logic [2:0] CMD_UNION     = 3'd6;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] a_left;
    logic signed [31:0] a_top;
    logic signed [31:0] a_right;
    logic signed [31:0] a_bottom;
    logic signed [31:0] b_left;
    logic signed [31:0] b_top;
    logic signed [31:0] b_right;
    logic signed [31:0] b_bottom;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
  } rau_in_t;

  typedef struct packed {
    logic signed [31:0] out_left;
    logic signed [31:0] out_top;
    logic signed [31:0] out_right;
    logic signed [31:0] out_bottom;
    logic               flag;
  } rau_out_t;

  // per-axis compare results
  typedef struct packed {
    logic alo_lt_ahi;
    logic alo_lt_bhi;
    logic blo_lt_ahi;
    logic blo_lt_bhi;
    logic alo_lt_blo;
    logic ahi_lt_bhi;
    logic pt_ge_alo;
    logic pt_lt_ahi;
    logic lo_eq;
    logic hi_eq;
  } rau_axis_flags_t;

endpackage

`default_nettype wire

>>> hw/rtl/rau_axis.sv
// ----------------------------------------------------------------------------
// rau_axis
// one axis of the rectangle unit: edge compares and edge sums, registered
// ----------------------------------------------------------------------------
`default_nettype none

module rau_axis #(
  parameter int CW = 32
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic signed [CW-1:0]   a_lo,
  input  logic signed [CW-1:0]   a_hi,
  input  logic signed [CW-1:0]   b_lo,
  input  logic signed [CW-1:0]   b_hi,
  input  logic signed [CW-1:0]   pt,
  output logic signed [CW-1:0]   a_lo_q,
  output logic signed [CW-1:0]   a_hi_q,
  output logic signed [CW-1:0]   b_lo_q,
  output logic signed [CW-1:0]   b_hi_q,
  output logic signed [CW-1:0]   infl_lo_q,
  output logic signed [CW-1:0]   off_lo_q,
  output logic signed [CW-1:0]   hi_add_q,
  output rau_pkg::rau_axis_flags_t flags_q
);

  logic signed [CW-1:0]     a_lo_r, a_hi_r, b_lo_r, b_hi_r;
  logic signed [CW-1:0]     infl_lo_r, off_lo_r, hi_add_r;
  rau_pkg::rau_axis_flags_t flags_r;
  rau_pkg::rau_axis_flags_t flags_nxt;

  always_comb begin
    flags_nxt.alo_lt_ahi = a_lo < a_hi;
    flags_nxt.alo_lt_bhi = a_lo < b_hi;
    flags_nxt.blo_lt_ahi = b_lo < a_hi;
    flags_nxt.blo_lt_bhi = b_lo < b_hi;
    flags_nxt.alo_lt_blo = a_lo < b_lo;
    flags_nxt.ahi_lt_bhi = a_hi < b_hi;
    flags_nxt.pt_ge_alo  = !(pt < a_lo);
    flags_nxt.pt_lt_ahi  = pt < a_hi;
    flags_nxt.lo_eq      = a_lo == b_lo;
    flags_nxt.hi_eq      = a_hi == b_hi;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_lo_r    <= a_lo;
      a_hi_r    <= a_hi;
      b_lo_r    <= b_lo;
      b_hi_r    <= b_hi;
      infl_lo_r <= a_lo - pt;
      off_lo_r  <= a_lo + pt;
      hi_add_r  <= a_hi + pt;
      flags_r   <= flags_nxt;
    end
  end

  assign a_lo_q    = a_lo_r;
  assign a_hi_q    = a_hi_r;
  assign b_lo_q    = b_lo_r;
  assign b_hi_q    = b_hi_r;
  assign infl_lo_q = infl_lo_r;
  assign off_lo_q  = off_lo_r;
  assign hi_add_q  = hi_add_r;
  assign flags_q   = flags_r;

endmodule

`default_nettype wire

>>> hw/rtl/rectangle_algebra_unit.sv
// ----------------------------------------------------------------------------
// rectangle_algebra_unit
// half-open rectangle operations: point test, empty test, equality,
// inflate, offset, intersection and union
// out_valid strobes once an accepted start has passed through every stage register
// throughput: one transaction per cycle, busy is always low
// stages: input register, edge compares and sums, result select
// reset clears the stage valid bits only; the receiver cannot stall
// ----------------------------------------------------------------------------
`default_nettype none

module rectangle_algebra_unit #(
  parameter int COORD_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  rau_pkg::rau_in_t  in_data,
  output logic              out_valid,
  output rau_pkg::rau_out_t out_data
);

  localparam int CW = COORD_WIDTH;

  function automatic logic signed [CW-1:0] cut(input logic [31:0] v);
    logic [63:0] z;
    z = {32'b0, v};
    return z[CW-1:0];
  endfunction

  function automatic logic signed [31:0] widen(input logic signed [CW-1:0] v);
    logic [63:0] e;
    e = 64'(v);
    return e[31:0];
  endfunction

  // stage 1: input register
  logic                 v1_r;
  logic [2:0]           cmd1_r;
  logic signed [CW-1:0] al_r, at_r, ar_r, ab_r, bl_r, bt_r, br_r, bb_r, x_r, y_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cmd1_r <= in_data.cmd;
      al_r   <= cut(in_data.a_left);
      at_r   <= cut(in_data.a_top);
      ar_r   <= cut(in_data.a_right);
      ab_r   <= cut(in_data.a_bottom);
      bl_r   <= cut(in_data.b_left);
      bt_r   <= cut(in_data.b_top);
      br_r   <= cut(in_data.b_right);
      bb_r   <= cut(in_data.b_bottom);
      x_r    <= cut(in_data.coord_x);
      y_r    <= cut(in_data.coord_y);
    end
  end

  // stage 2: per-axis compares and sums
  logic       v2_r;
  logic [2:0] cmd2_r;

  logic signed [CW-1:0] xa_lo, xa_hi, xb_lo, xb_hi, x_infl, x_off, x_hi_add;
  logic signed [CW-1:0] ya_lo, ya_hi, yb_lo, yb_hi, y_infl, y_off, y_hi_add;
  rau_pkg::rau_axis_flags_t fx, fy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (v1_r) begin
      cmd2_r <= cmd1_r;
    end
  end

  rau_axis #(.CW(CW)) u_axis_x (
    .clk       (clk),
    .en        (v1_r),
    .a_lo      (al_r),
    .a_hi      (ar_r),
    .b_lo      (bl_r),
    .b_hi      (br_r),
    .pt        (x_r),
    .a_lo_q    (xa_lo),
    .a_hi_q    (xa_hi),
    .b_lo_q    (xb_lo),
    .b_hi_q    (xb_hi),
    .infl_lo_q (x_infl),
    .off_lo_q  (x_off),
    .hi_add_q  (x_hi_add),
    .flags_q   (fx)
  );

  rau_axis #(.CW(CW)) u_axis_y (
    .clk       (clk),
    .en        (v1_r),
    .a_lo      (at_r),
    .a_hi      (ab_r),
    .b_lo      (bt_r),
    .b_hi      (bb_r),
    .pt        (y_r),
    .a_lo_q    (ya_lo),
    .a_hi_q    (ya_hi),
    .b_lo_q    (yb_lo),
    .b_hi_q    (yb_hi),
    .infl_lo_q (y_infl),
    .off_lo_q  (y_off),
    .hi_add_q  (y_hi_add),
    .flags_q   (fy)
  );

  // stage 3: result select
  logic signed [CW-1:0] res_l, res_t, res_r, res_b;
  logic                 flag_nxt;
  logic                 a_empty, b_empty, isect_ok;
  logic                 out_valid_r;
  rau_pkg::rau_out_t    out_data_r;
  rau_pkg::rau_out_t    out_data_nxt;

  always_comb begin
    a_empty  = !fx.alo_lt_ahi || !fy.alo_lt_ahi;
    b_empty  = !fx.blo_lt_bhi || !fy.blo_lt_bhi;
    isect_ok = fx.alo_lt_ahi && fx.alo_lt_bhi && fx.blo_lt_ahi && fx.blo_lt_bhi &&
               fy.alo_lt_ahi && fy.alo_lt_bhi && fy.blo_lt_ahi && fy.blo_lt_bhi;
    res_l    = xa_lo;
    res_t    = ya_lo;
    res_r    = xa_hi;
    res_b    = ya_hi;
    flag_nxt = 1'b0;
    unique case (cmd2_r)
      rau_pkg::CMD_POINT_IN: begin
        flag_nxt = fx.pt_ge_alo && fx.pt_lt_ahi && fy.pt_ge_alo && fy.pt_lt_ahi;
      end
      rau_pkg::CMD_IS_EMPTY: begin
        flag_nxt = a_empty;
      end
      rau_pkg::CMD_EQUAL: begin
        flag_nxt = fx.lo_eq && fx.hi_eq && fy.lo_eq && fy.hi_eq;
      end
      rau_pkg::CMD_INFLATE: begin
        res_l    = x_infl;
        res_t    = y_infl;
        res_r    = x_hi_add;
        res_b    = y_hi_add;
        flag_nxt = 1'b1;
      end
      rau_pkg::CMD_OFFSET: begin
        res_l    = x_off;
        res_t    = y_off;
        res_r    = x_hi_add;
        res_b    = y_hi_add;
        flag_nxt = 1'b1;
      end
      rau_pkg::CMD_INTERSECT: begin
        if (isect_ok) begin
          res_l    = fx.alo_lt_blo ? xb_lo : xa_lo;
          res_t    = fy.alo_lt_blo ? yb_lo : ya_lo;
          res_r    = fx.ahi_lt_bhi ? xa_hi : xb_hi;
          res_b    = fy.ahi_lt_bhi ? ya_hi : yb_hi;
          flag_nxt = 1'b1;
        end else begin
          res_l    = '0;
          res_t    = '0;
          res_r    = '0;
          res_b    = '0;
          flag_nxt = 1'b0;
        end
      end
      rau_pkg::CMD_UNION: begin
        if (a_empty && b_empty) begin
          res_l    = '0;
          res_t    = '0;
          res_r    = '0;
          res_b    = '0;
          flag_nxt = 1'b0;
        end else if (a_empty) begin
          res_l    = xb_lo;
          res_t    = yb_lo;
          res_r    = xb_hi;
          res_b    = yb_hi;
          flag_nxt = 1'b1;
        end else if (b_empty) begin
          flag_nxt = 1'b1;
        end else begin
          res_l    = fx.alo_lt_blo ? xa_lo : xb_lo;
          res_t    = fy.alo_lt_blo ? ya_lo : yb_lo;
          res_r    = fx.ahi_lt_bhi ? xb_hi : xa_hi;
          res_b    = fy.ahi_lt_bhi ? yb_hi : ya_hi;
          flag_nxt = 1'b1;
        end
      end
      default: begin
        flag_nxt = 1'b0;
      end
    endcase
    out_data_nxt.out_left   = widen(res_l);
    out_data_nxt.out_top    = widen(res_t);
    out_data_nxt.out_right  = widen(res_r);
    out_data_nxt.out_bottom = widen(res_b);
    out_data_nxt.flag       = flag_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (v2_r) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
